@@ sv/lcws_pkg.sv @@
`default_nettype none
package lcws_pkg;

	// action codes of an input transaction
	localparam logic [1:0] ACT_MEASURE = 2'd0;
	localparam logic [1:0] ACT_TARE    = 2'd1;
	localparam logic [1:0] ACT_FAIL    = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_SCALE  = 3'd0;
	localparam logic [2:0] REG_LOW_R  = 3'd1;
	localparam logic [2:0] REG_LOW_G  = 3'd2;
	localparam logic [2:0] REG_HIGH_R = 3'd3;
	localparam logic [2:0] REG_HIGH_G = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;

	// grams per kilogram with the 8 fraction bits of the scale folded in
	localparam logic [31:0] GRAM_Q8 = 32'd256000;

	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 52;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [23:0] raw_sample;
	} in_t;

	typedef struct packed {
		logic signed [23:0] weight_grams;
		logic               is_stable;
		logic               read_failed;
		logic signed [23:0] last_raw;
		logic               tare_done;
		logic               two_point_active;
	} out_t;

	function automatic logic [23:0] abs24(input logic [23:0] x);
		abs24 = x[23] ? 24'(-x) : x;
	endfunction

	function automatic logic [24:0] abs25(input logic [24:0] x);
		abs25 = x[24] ? 25'(-x) : x;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] x);
		abs32 = x[31] ? 32'(-x) : x;
	endfunction

	function automatic logic [52:0] abs53(input logic [52:0] x);
		abs53 = x[52] ? 53'(-x) : x;
	endfunction

	// saturate a sign and magnitude quotient to 24 bits
	function automatic logic [23:0] sat24(input logic [51:0] mag, input logic neg);
		if (!neg) begin
			sat24 = (mag > 52'd8388607) ? 24'h7FFFFF : mag[23:0];
		end else begin
			sat24 = (mag > 52'd8388608) ? 24'h800000 : 24'(-mag[23:0]);
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/load_cell_weight_and_stability.sv @@
// a read failure, an unused code or a tare sample that does not complete the average
//   goes straight to the result; a completing tare first does a serial divide by the count
// measure: 7 products single point, 8 products two point, with a divide after the first
//   products: 1-bit serial multiplier and 1-bit restoring divider
// a new transaction is taken only in idle, not while one is in work or waits to be loaded
// reset: asynchronous; weight, tare and window clear, stable set, config to defaults
`default_nettype none
module load_cell_weight_and_stability
	import lcws_pkg::*;
#(
	parameter int WINDOW = 8,
	parameter int TARE_COUNT = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		OP_P1, OP_P2, OP_DW, OP_DT, OP_WSQ, OP_OSQ, OP_WQ, OP_SSQ, OP_LW, OP_LWW
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [5:0] cnt_q;

	// configuration
	logic [31:0] scale_q;
	logic signed [23:0] low_r_q, low_g_q, high_r_q, high_g_q;
	logic [45:0] limit_q;

	// block state
	logic signed [23:0] tare_offset_q;
	logic signed [31:0] tare_sum_q;
	logic [7:0] tare_count_q;
	logic signed [23:0] hist_q [WINDOW];
	logic [POS_W-1:0] hist_pos_q;
	logic signed [31:0] win_sum_q;
	logic [55:0] win_sq_q;
	logic signed [23:0] weight_q;
	logic stable_q, error_q, done_q, tp_path_q;
	logic signed [23:0] raw_last_q;
	logic signed [23:0] old_q;

	// serial arithmetic
	logic [55:0] mul_a_q;
	logic [31:0] mul_b_q;
	logic [87:0] mul_p_q;
	logic        neg_q;
	logic signed [52:0] num_q;
	logic [46:0] sq_w_q;
	logic [56:0] wq_q, ssq_q;
	logic [51:0] div_d_q;
	logic [31:0] div_r_q, div_v_q;

	out_t out_q;
	logic out_valid_q;

	// config port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[5:3])
			REG_SCALE:  prdata = {32'd0, scale_q};
			REG_LOW_R:  prdata = {40'd0, low_r_q};
			REG_LOW_G:  prdata = {40'd0, low_g_q};
			REG_HIGH_R: prdata = {40'd0, high_r_q};
			REG_HIGH_G: prdata = {40'd0, high_g_q};
			REG_LIMIT:  prdata = {18'd0, limit_q};
			default:    prdata = 64'd0;
		endcase
	end

	// two-point calibration terms
	logic tp_valid;
	logic signed [24:0] span, gspan, raw_lo, raw_tare;
	assign tp_valid = (low_r_q != high_r_q) && (low_g_q != high_g_q)
		&& !(low_r_q == 24'sd0 && low_g_q == 24'sd0)
		&& !(high_r_q == 24'sd0 && high_g_q == 24'sd0);
	assign span     = {high_r_q[23], high_r_q} - {low_r_q[23], low_r_q};
	assign gspan    = {high_g_q[23], high_g_q} - {low_g_q[23], low_g_q};
	assign raw_lo   = {raw_last_q[23], raw_last_q} - {low_r_q[23], low_r_q};
	assign raw_tare = {in_data.raw_sample[23], in_data.raw_sample}
		- {tare_offset_q[23], tare_offset_q};

	// one multiplier bit per cycle
	logic [56:0] mul_sum;
	logic [87:0] mul_p_nx;
	assign mul_sum  = {1'b0, mul_p_q[87:32]} + (mul_b_q[0] ? {1'b0, mul_a_q} : 57'd0);
	assign mul_p_nx = {mul_sum, mul_p_q[31:1]};

	// one quotient bit per cycle
	logic [32:0] div_sh;
	logic        div_ge;
	logic [31:0] div_r_nx;
	logic [51:0] div_d_nx;
	assign div_sh   = {div_r_q, div_d_q[51]};
	assign div_ge   = div_sh >= {1'b0, div_v_q};
	assign div_r_nx = div_ge ? 32'(div_sh - {1'b0, div_v_q}) : div_sh[31:0];
	assign div_d_nx = {div_d_q[50:0], div_ge};

	logic signed [52:0] prod_s, num_sum;
	logic [52:0] num_abs;
	logic [23:0] quot_sat;
	logic [55:0] win_sq_nx;
	logic signed [31:0] tare_sum_nx;
	logic [8:0] tare_count_nx;
	assign prod_s    = neg_q ? 53'(-mul_p_nx[52:0]) : mul_p_nx[52:0];
	assign num_sum   = num_q + prod_s;
	assign num_abs   = abs53(num_sum);
	assign quot_sat  = sat24(div_d_nx, neg_q);
	assign win_sq_nx = win_sq_q + 56'(sq_w_q) - mul_p_nx[55:0];
	assign tare_sum_nx   = tare_sum_q + 32'(in_data.raw_sample);
	assign tare_count_nx = {1'b0, tare_count_q} + 9'd1;

	logic in_acc;
	logic out_load;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_P1;
			cnt_q <= '0;
			scale_q <= 32'd256;
			low_r_q <= '0;
			low_g_q <= '0;
			high_r_q <= '0;
			high_g_q <= '0;
			limit_q <= 46'd40000;
			tare_offset_q <= '0;
			tare_sum_q <= '0;
			tare_count_q <= '0;
			for (int i = 0; i < WINDOW; i++) hist_q[i] <= '0;
			hist_pos_q <= '0;
			win_sum_q <= '0;
			win_sq_q <= '0;
			weight_q <= '0;
			stable_q <= 1'b1;
			error_q <= 1'b0;
			done_q <= 1'b0;
			raw_last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// config writes
			if (cfg_wr) begin
				unique case (paddr[5:3])
					REG_SCALE:  scale_q <= pwdata[31:0];
					REG_LOW_R:  low_r_q <= pwdata[23:0];
					REG_LOW_G:  low_g_q <= pwdata[23:0];
					REG_HIGH_R: high_r_q <= pwdata[23:0];
					REG_HIGH_G: high_g_q <= pwdata[23:0];
					REG_LIMIT:  limit_q <= pwdata[45:0];
					default: ;
				endcase
			end

			// output register valid
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_data.action)
							ACT_MEASURE: begin
								done_q <= 1'b0;
								error_q <= 1'b0;
								raw_last_q <= in_data.raw_sample;
								tp_path_q <= tp_valid;
								mul_p_q <= '0;
								cnt_q <= '0;
								op_q <= OP_P1;
								state_q <= ST_MUL;
								if (tp_valid) begin
									mul_a_q <= 56'(abs24(low_g_q));
									mul_b_q <= 32'(abs25(span));
									neg_q <= low_g_q[23] ^ span[24];
								end else begin
									mul_a_q <= 56'(abs25(raw_tare));
									mul_b_q <= GRAM_Q8;
									neg_q <= raw_tare[24];
								end
							end
							ACT_TARE: begin
								raw_last_q <= in_data.raw_sample;
								if (tare_count_nx >= 9'(TARE_COUNT)) begin
									tare_sum_q <= '0;
									tare_count_q <= '0;
									weight_q <= '0;
									error_q <= 1'b0;
									for (int i = 0; i < WINDOW; i++) hist_q[i] <= '0;
									hist_pos_q <= '0;
									win_sum_q <= '0;
									win_sq_q <= '0;
									stable_q <= 1'b1;
									done_q <= 1'b1;
									div_d_q <= 52'(abs32(tare_sum_nx));
									div_r_q <= '0;
									div_v_q <= 32'(TARE_COUNT);
									neg_q <= tare_sum_nx[31];
									cnt_q <= '0;
									op_q <= OP_DT;
									state_q <= ST_DIV;
								end else begin
									tare_sum_q <= tare_sum_nx;
									tare_count_q <= tare_count_nx[7:0];
									done_q <= 1'b0;
									state_q <= ST_DONE;
								end
							end
							ACT_FAIL: begin
								error_q <= 1'b1;
								done_q <= 1'b0;
								state_q <= ST_DONE;
							end
							default: begin
								done_q <= 1'b0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				ST_MUL: begin
					if (cnt_q == 6'(MUL_STEPS - 1)) begin
						// product done: take it and set up the next operation
						cnt_q <= '0;
						mul_p_q <= '0;
						unique case (op_q)
							OP_P1: begin
								if (tp_path_q) begin
									num_q <= prod_s;
									mul_a_q <= 56'(abs25(raw_lo));
									mul_b_q <= 32'(abs25(gspan));
									neg_q <= raw_lo[24] ^ gspan[24];
									op_q <= OP_P2;
								end else begin
									div_d_q <= mul_p_nx[51:0];
									div_r_q <= '0;
									div_v_q <= (scale_q == 32'd0) ? 32'd1 : scale_q;
									op_q <= OP_DW;
									state_q <= ST_DIV;
								end
							end
							OP_P2: begin
								div_d_q <= num_abs[51:0];
								div_r_q <= '0;
								div_v_q <= 32'(abs25(span));
								neg_q <= num_sum[52] ^ span[24];
								op_q <= OP_DW;
								state_q <= ST_DIV;
							end
							OP_WSQ: begin
								sq_w_q <= mul_p_nx[46:0];
								mul_a_q <= 56'(abs24(old_q));
								mul_b_q <= 32'(abs24(old_q));
								op_q <= OP_OSQ;
							end
							OP_OSQ: begin
								win_sq_q <= win_sq_nx;
								mul_a_q <= win_sq_nx;
								mul_b_q <= 32'(WINDOW);
								op_q <= OP_WQ;
							end
							OP_WQ: begin
								wq_q <= mul_p_nx[56:0];
								mul_a_q <= 56'(abs32(win_sum_q));
								mul_b_q <= abs32(win_sum_q);
								op_q <= OP_SSQ;
							end
							OP_SSQ: begin
								ssq_q <= mul_p_nx[56:0];
								mul_a_q <= 56'(limit_q);
								mul_b_q <= 32'(WINDOW);
								op_q <= OP_LW;
							end
							OP_LW: begin
								mul_a_q <= mul_p_nx[55:0];
								mul_b_q <= 32'(WINDOW);
								op_q <= OP_LWW;
							end
							OP_LWW: begin
								stable_q <= (wq_q - ssq_q) < mul_p_nx[56:0];
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end else begin
						mul_p_q <= mul_p_nx;
						mul_b_q <= {1'b0, mul_b_q[31:1]};
						cnt_q <= cnt_q + 6'd1;
					end
				end

				ST_DIV: begin
					div_d_q <= div_d_nx;
					div_r_q <= div_r_nx;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						cnt_q <= '0;
						if (op_q == OP_DT) begin
							tare_offset_q <= quot_sat;
							state_q <= ST_DONE;
						end else begin
							// new weight enters the window
							weight_q <= quot_sat;
							old_q <= hist_q[hist_pos_q];
							hist_q[hist_pos_q] <= quot_sat;
							hist_pos_q <= (hist_pos_q == POS_W'(WINDOW - 1)) ? '0
								: hist_pos_q + POS_W'(1);
							win_sum_q <= win_sum_q + 32'(signed'(quot_sat))
								- 32'(hist_q[hist_pos_q]);
							mul_p_q <= '0;
							mul_a_q <= 56'(abs24(quot_sat));
							mul_b_q <= 32'(abs24(quot_sat));
							op_q <= OP_WSQ;
							state_q <= ST_MUL;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end

				ST_DONE: begin
					// result transaction waits for a free output register
					if (out_load) begin
						out_q.weight_grams <= weight_q;
						out_q.is_stable <= stable_q;
						out_q.read_failed <= error_q;
						out_q.last_raw <= raw_last_q;
						out_q.tare_done <= done_q;
						out_q.two_point_active <= tp_valid;
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hist_pos_q) < WINDOW)
		else $error("window position out of range");

	a_tare_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.tare_done) |->
		(!out_data.read_failed && out_data.is_stable && out_data.weight_grams == 24'sd0))
		else $error("tare result with stale weight or flags");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < 6'(MUL_STEPS)))
		else $error("multiplier step count overrun");
`endif

endmodule
`default_nettype wire
